### sv/line_editor_word_wrap_macros.svh
`ifndef LINE_EDITOR_WORD_WRAP_MACROS_SVH
`define LINE_EDITOR_WORD_WRAP_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock out of reset
`define LEW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lew assertion failed");

// expression must never be true out of reset
`define LEW_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lew assertion failed");

`else

`define LEW_ASSERT(name, prop)
`define LEW_ASSERT_NEVER(name, expr)

`endif

`endif

### sv/lew_pkg.sv
package lew_pkg;

  typedef enum logic [2:0] {
    ACT_ECHO    = 3'd0,
    ACT_ERASE   = 3'd1,
    ACT_BELL    = 3'd2,
    ACT_NEWLINE = 3'd3,
    ACT_EXIT    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CMD_RUBOUT,
    CMD_KILL,
    CMD_WERASE,
    CMD_EOF,
    CMD_NEWLINE,
    CMD_PRINT,
    CMD_OTHER
  } cmd_e;

  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_CTRLU = 8'h15;
  localparam logic [7:0] KEY_CTRLW = 8'h17;
  localparam logic [7:0] KEY_CTRLD = 8'h04;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  function automatic logic is_blank(logic [7:0] c);
    return (c == KEY_SPACE) || (c == KEY_TAB);
  endfunction

endpackage

### sv/lew_decode.sv
module lew_decode (
  input  logic [7:0]   byte_i,
  output lew_pkg::cmd_e cmd_o
);

  always_comb begin
    unique case (byte_i) inside
      lew_pkg::KEY_DEL, lew_pkg::KEY_BS: cmd_o = lew_pkg::CMD_RUBOUT;
      lew_pkg::KEY_CTRLU:                cmd_o = lew_pkg::CMD_KILL;
      lew_pkg::KEY_CTRLW:                cmd_o = lew_pkg::CMD_WERASE;
      lew_pkg::KEY_CTRLD:                cmd_o = lew_pkg::CMD_EOF;
      lew_pkg::KEY_LF, lew_pkg::KEY_CR:  cmd_o = lew_pkg::CMD_NEWLINE;
      [lew_pkg::PRINT_LO:lew_pkg::PRINT_HI]: cmd_o = lew_pkg::CMD_PRINT;
      default:                           cmd_o = lew_pkg::CMD_OTHER;
    endcase
  end

endmodule

### sv/line_editor_word_wrap.sv
// Line editor with word wrap. Each typed byte is taken on the input channel and answered by a
// run of display words on the output channel (echo, erase n, bell, newline, exit); the last
// word of a run carries last_of_run. A byte that causes nothing (Ctrl-U on an empty line, any
// byte after exit) gives no word. The line lives in a one-port-read, one-port-write memory of
// LINE_WIDTH+1 bytes with a registered read, walked one entry per cycle while the output is
// not stalled. Ctrl-W walks back over the trailing blanks and then the last word, and a wrap
// does a backward search for the last blank, then reads the head and tail back in order,
// copying the tail to the front as it goes. A new byte is taken once the previous run has
// been placed in the output register.
module line_editor_word_wrap #(
  parameter int LINE_WIDTH = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] typed_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] glyph_o,
  output logic [5:0] erase_count_o,
  output logic       last_of_run_o
);

`include "line_editor_word_wrap_macros.svh"

  localparam int         Depth = LINE_WIDTH + 1;
  localparam int         AW    = $clog2(Depth);
  localparam logic [5:0] LW6   = 6'(LINE_WIDTH);
  localparam logic [5:0] DEP6  = 6'(Depth);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CMD    = 10'b00_0000_0010,
    S_WBLANK = 10'b00_0000_0100,
    S_WWORD  = 10'b00_0000_1000,
    S_WDONE  = 10'b00_0001_0000,
    S_SEARCH = 10'b00_0010_0000,
    S_ERASE  = 10'b00_0100_0000,
    S_HEAD   = 10'b00_1000_0000,
    S_NL     = 10'b01_0000_0000,
    S_TAIL   = 10'b10_0000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  start_q, start_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  split_q, split_d;
  logic        halted_q, halted_d;
  logic [7:0]  byte_q;
  logic [7:0]  rdata_q;
  logic [7:0]  mem [Depth];

  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]  wr_data;
  logic [5:0]  rd_idx, tail_len;

  logic        emit, e_last;
  lew_pkg::action_e e_act;
  logic [7:0]  e_glyph;
  logic [5:0]  e_cnt;

  logic        out_valid_q, last_q;
  lew_pkg::action_e act_q;
  logic [7:0]  glyph_q;
  logic [5:0]  cnt_q;
  logic        out_free, rblank;
  lew_pkg::cmd_e cmd;

  lew_decode u_decode (
    .byte_i (byte_q),
    .cmd_o  (cmd)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rblank     = lew_pkg::is_blank(rdata_q);
  assign tail_len   = DEP6 - split_q;
  assign rd_addr    = rd_idx[AW-1:0];

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    start_d  = start_q;
    idx_d    = idx_q;
    split_d  = split_q;
    halted_d = halted_q;
    rd_en    = 1'b0;
    rd_idx   = '0;
    wr_en    = 1'b0;
    wr_addr  = fill_q[AW-1:0];
    wr_data  = byte_q;
    emit     = 1'b0;
    e_act    = lew_pkg::ACT_BELL;
    e_glyph  = '0;
    e_cnt    = '0;
    e_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CMD;
        end
      end

      S_CMD: begin
        if (halted_q) begin
          state_d = S_IDLE;
        end else begin
          unique case (cmd)
            lew_pkg::CMD_RUBOUT: begin
              if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                state_d = S_IDLE;
                if (fill_q != '0) begin
                  e_act  = lew_pkg::ACT_ERASE;
                  e_cnt  = 6'd1;
                  fill_d = fill_q - 6'd1;
                end
              end
            end
            lew_pkg::CMD_KILL: begin
              if (fill_q == '0) begin
                state_d = S_IDLE;
              end else if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                e_act   = lew_pkg::ACT_ERASE;
                e_cnt   = fill_q;
                fill_d  = '0;
                state_d = S_IDLE;
              end
            end
            lew_pkg::CMD_WERASE: begin
              start_d = fill_q;
              if (fill_q == '0) begin
                state_d = S_WDONE;
              end else begin
                rd_en   = 1'b1;
                rd_idx  = fill_q - 6'd1;
                state_d = S_WBLANK;
              end
            end
            lew_pkg::CMD_EOF: begin
              if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                state_d = S_IDLE;
                if (fill_q == '0) begin
                  e_act    = lew_pkg::ACT_EXIT;
                  halted_d = 1'b1;
                end
              end
            end
            lew_pkg::CMD_NEWLINE: begin
              if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                e_act   = lew_pkg::ACT_NEWLINE;
                fill_d  = '0;
                state_d = S_IDLE;
              end
            end
            lew_pkg::CMD_PRINT: begin
              wr_en = 1'b1;
              if (fill_q == LW6) begin
                fill_d  = DEP6;
                idx_d   = LW6 - 6'd1;
                split_d = LW6;
                rd_en   = 1'b1;
                rd_idx  = LW6 - 6'd1;
                state_d = S_SEARCH;
              end else if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                e_act   = lew_pkg::ACT_ECHO;
                e_glyph = byte_q;
                fill_d  = fill_q + 6'd1;
                state_d = S_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                state_d = S_IDLE;
              end
            end
          endcase
        end
      end

      S_WBLANK: begin
        if (rblank) begin
          fill_d = fill_q - 6'd1;
          if (fill_q == 6'd1) begin
            state_d = S_WDONE;
          end else begin
            rd_en  = 1'b1;
            rd_idx = fill_q - 6'd2;
          end
        end else begin
          state_d = S_WWORD;
        end
      end

      S_WWORD: begin
        if (!rblank) begin
          fill_d = fill_q - 6'd1;
          if (fill_q == 6'd1) begin
            state_d = S_WDONE;
          end else begin
            rd_en  = 1'b1;
            rd_idx = fill_q - 6'd2;
          end
        end else begin
          state_d = S_WDONE;
        end
      end

      S_WDONE: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
          if (start_q != fill_q) begin
            e_act = lew_pkg::ACT_ERASE;
            e_cnt = start_q - fill_q;
          end
        end
      end

      S_SEARCH: begin
        if (rblank) begin
          split_d = idx_q + 6'd1;
          state_d = S_ERASE;
        end else if (idx_q == '0) begin
          state_d = S_ERASE;
        end else begin
          idx_d  = idx_q - 6'd1;
          rd_en  = 1'b1;
          rd_idx = idx_q - 6'd1;
        end
      end

      S_ERASE: begin
        if (out_free) begin
          emit    = 1'b1;
          e_act   = lew_pkg::ACT_ERASE;
          e_cnt   = LW6;
          idx_d   = '0;
          rd_en   = 1'b1;
          rd_idx  = '0;
          state_d = S_HEAD;
        end
      end

      S_HEAD: begin
        if (out_free) begin
          emit    = 1'b1;
          e_act   = lew_pkg::ACT_ECHO;
          e_glyph = rdata_q;
          if (idx_q + 6'd1 == split_q) begin
            state_d = S_NL;
          end else begin
            idx_d  = idx_q + 6'd1;
            rd_en  = 1'b1;
            rd_idx = idx_q + 6'd1;
          end
        end
      end

      S_NL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_act   = lew_pkg::ACT_NEWLINE;
          idx_d   = '0;
          rd_en   = 1'b1;
          rd_idx  = split_q;
          state_d = S_TAIL;
        end
      end

      S_TAIL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_act   = lew_pkg::ACT_ECHO;
          e_glyph = rdata_q;
          wr_en   = 1'b1;
          wr_addr = idx_q[AW-1:0];
          wr_data = rdata_q;
          if (idx_q + 6'd1 == tail_len) begin
            e_last  = 1'b1;
            fill_d  = tail_len;
            state_d = S_IDLE;
          end else begin
            idx_d  = idx_q + 6'd1;
            rd_en  = 1'b1;
            rd_idx = split_q + idx_q + 6'd1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      byte_q <= typed_byte_i;
    end
    if (emit) begin
      act_q   <= e_act;
      glyph_q <= e_glyph;
      cnt_q   <= e_cnt;
      last_q  <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      start_q     <= '0;
      idx_q       <= '0;
      split_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      start_q  <= start_d;
      idx_q    <= idx_d;
      split_q  <= split_d;
      halted_q <= halted_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = act_q;
  assign glyph_o       = glyph_q;
  assign erase_count_o = cnt_q;
  assign last_of_run_o = last_q;

  `LEW_ASSERT(a_idle_fill, (state_q == S_IDLE) |-> (fill_q <= LW6))
  `LEW_ASSERT(a_halt_silent, (halted_q && !out_valid_q) |=> !out_valid_q)
  `LEW_ASSERT(a_head_in_range, (state_q == S_HEAD) |-> (idx_q < split_q && split_q <= LW6))
  `LEW_ASSERT_NEVER(a_tail_in_range, (state_q == S_TAIL) && (7'(split_q) + 7'(idx_q) > 7'(LW6)))

endmodule

### verif/line_editor_word_wrap_tb.sv
module line_editor_word_wrap_tb;

  localparam int LW             = 40;
  localparam int N_DIR          = 25;
  localparam int N_RAND         = 450;
  localparam int QUIET_LO       = 250;
  localparam int QUIET_HI       = 330;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    lew_pkg::action_e action;
    logic [7:0]       glyph;
    logic [5:0]       count;
    logic             last;
  } disp_word_t;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    logic [7:0]       key;
    row_check_e       check;
    lew_pkg::action_e action;
    logic [7:0]       glyph;
    logic [5:0]       count;
  } key_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] typed_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] action;
  logic [7:0] glyph;
  logic [5:0] erase_count;
  logic       last_of_run;

  // editor image kept by the testbench
  logic [7:0] line_img [0:LW];
  int         fill;
  bit         stopped;

  disp_word_t pending_words [$];
  disp_word_t run_buf [0:63];
  int         run_len;

  int  mismatches;
  int  words_checked;
  int  keys_sent;
  int  wraps;
  int  hard_wraps;
  int  nospace_left;
  bit  quiet;

  key_row_t dir_rows [N_DIR] = '{
    '{lew_pkg::KEY_BS,    CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{lew_pkg::KEY_DEL,   CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLU, CHK_NONE,    lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLW, CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{8'h00,              CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{8'hFF,              CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{8'h80,              CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{lew_pkg::KEY_TAB,   CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{lew_pkg::PRINT_LO,  CHK_ONE,     lew_pkg::ACT_ECHO,    lew_pkg::PRINT_LO, 6'd0},
    '{lew_pkg::PRINT_HI,  CHK_ONE,     lew_pkg::ACT_ECHO,    lew_pkg::PRINT_HI, 6'd0},
    '{8'h61,              CHK_ONE,     lew_pkg::ACT_ECHO,    8'h61, 6'd0},
    '{lew_pkg::KEY_CTRLD, CHK_ONE,     lew_pkg::ACT_BELL,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLW, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLW, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{8'h78,              CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_BS,    CHK_ONE,     lew_pkg::ACT_ERASE,   8'h00, 6'd1},
    '{8'h79,              CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_SPACE, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_SPACE, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLW, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{8'h5A,              CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{8'h7A,              CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_CTRLU, CHK_PREDICT, lew_pkg::ACT_ECHO,    8'h00, 6'd0},
    '{lew_pkg::KEY_LF,    CHK_ONE,     lew_pkg::ACT_NEWLINE, 8'h00, 6'd0},
    '{lew_pkg::KEY_CR,    CHK_ONE,     lew_pkg::ACT_NEWLINE, 8'h00, 6'd0}
  };

  line_editor_word_wrap #(
    .LINE_WIDTH(LW)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .typed_byte_i  (typed_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .action_o      (action),
    .glyph_o       (glyph),
    .erase_count_o (erase_count),
    .last_of_run_o (last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit blank_char(logic [7:0] c);
    return (c == lew_pkg::KEY_SPACE) || (c == lew_pkg::KEY_TAB);
  endfunction

  function automatic void add_word(lew_pkg::action_e act, logic [7:0] g, int n);
    run_buf[run_len] = disp_word_t'{act, g, n[5:0], 1'b0};
    run_len++;
  endfunction

  // line wrap: erase shown line, echo head, newline, echo tail and keep it
  function automatic void wrap_line_img();
    int split;
    int tail;
    split = LW;
    for (int i = LW; i > 0; i--) begin
      if (blank_char(line_img[i-1])) begin
        split = i;
        break;
      end
    end
    wraps++;
    if (split == LW && !blank_char(line_img[LW-1])) hard_wraps++;
    add_word(lew_pkg::ACT_ERASE, 8'h00, LW);
    for (int i = 0; i < split; i++) add_word(lew_pkg::ACT_ECHO, line_img[i], 0);
    add_word(lew_pkg::ACT_NEWLINE, 8'h00, 0);
    tail = fill - split;
    for (int i = 0; i < tail; i++) begin
      add_word(lew_pkg::ACT_ECHO, line_img[split+i], 0);
      line_img[i] = line_img[split+i];
    end
    fill = tail;
  endfunction

  // editor response to one accepted key; queued only when record is set
  function automatic void apply_key(logic [7:0] b, bit record);
    int start;
    run_len = 0;
    if (stopped) return;
    if (b == lew_pkg::KEY_DEL || b == lew_pkg::KEY_BS) begin
      if (fill > 0) begin
        fill--;
        add_word(lew_pkg::ACT_ERASE, 8'h00, 1);
      end else begin
        add_word(lew_pkg::ACT_BELL, 8'h00, 0);
      end
    end else if (b == lew_pkg::KEY_CTRLU) begin
      if (fill > 0) begin
        add_word(lew_pkg::ACT_ERASE, 8'h00, fill);
        fill = 0;
      end
    end else if (b == lew_pkg::KEY_CTRLW) begin
      start = fill;
      while (fill > 0 && blank_char(line_img[fill-1])) fill--;
      while (fill > 0 && !blank_char(line_img[fill-1])) fill--;
      if (start != fill) add_word(lew_pkg::ACT_ERASE, 8'h00, start - fill);
      else add_word(lew_pkg::ACT_BELL, 8'h00, 0);
    end else if (b == lew_pkg::KEY_CTRLD) begin
      if (fill == 0) begin
        stopped = 1'b1;
        add_word(lew_pkg::ACT_EXIT, 8'h00, 0);
      end else begin
        add_word(lew_pkg::ACT_BELL, 8'h00, 0);
      end
    end else if (b == lew_pkg::KEY_LF || b == lew_pkg::KEY_CR) begin
      fill = 0;
      add_word(lew_pkg::ACT_NEWLINE, 8'h00, 0);
    end else if (b >= lew_pkg::PRINT_LO && b <= lew_pkg::PRINT_HI) begin
      line_img[fill] = b;
      fill++;
      if (fill > LW) wrap_line_img();
      else add_word(lew_pkg::ACT_ECHO, b, 0);
    end else begin
      add_word(lew_pkg::ACT_BELL, 8'h00, 0);
    end
    if (run_len > 0) run_buf[run_len-1].last = 1'b1;
    if (record) begin
      for (int i = 0; i < run_len; i++) pending_words.push_back(run_buf[i]);
    end
  endfunction

  // mostly words and blanks, with edit keys and noise mixed in
  function automatic logic [7:0] next_key();
    logic [7:0] key;
    int r;
    if (nospace_left == 0 && $urandom_range(0, 49) == 0) begin
      nospace_left = 60;
      return lew_pkg::KEY_SPACE;
    end
    r = $urandom_range(0, 99);
    if (r < 12) key = (nospace_left > 0) ? 8'($urandom_range(33, 126)) : lew_pkg::KEY_SPACE;
    else if (r < 80) key = 8'($urandom_range(33, 126));
    else if (r < 82) key = lew_pkg::KEY_BS;
    else if (r < 84) key = lew_pkg::KEY_DEL;
    else if (r < 86) key = lew_pkg::KEY_CTRLW;
    else if (r < 87) key = lew_pkg::KEY_CTRLU;
    else if (r < 88) key = $urandom_range(0, 1) ? lew_pkg::KEY_LF : lew_pkg::KEY_CR;
    else if (r < 89) key = lew_pkg::KEY_CTRLD;
    else if (r < 93) key = 8'($urandom_range(0, 31));
    else if (r < 96) key = 8'($urandom_range(128, 255));
    else key = 8'($urandom_range(33, 126));
    if (nospace_left > 0) nospace_left--;
    // exit only at the very end of the run
    if (key == lew_pkg::KEY_CTRLD && fill == 0) key = lew_pkg::KEY_BS;
    return key;
  endfunction

  task automatic send_key(logic [7:0] b, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    typed_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    keys_sent++;
  endtask

  task automatic send_typed(logic [7:0] b, lew_pkg::action_e act, logic [7:0] g,
                            logic [5:0] n);
    send_key(b, 1'b1);
    apply_key(b, 1'b0);
    pending_words.push_back(disp_word_t'{act, g, n, 1'b1});
  endtask

  always @(posedge clk) begin
    disp_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: action %0d glyph %0h erase_count %0d", action, glyph,
               erase_count);
        mismatches++;
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (action !== exp_w.action) begin
          $error("action: expected %0d, got %0d", exp_w.action, action);
          mismatches++;
        end
        if (glyph !== exp_w.glyph) begin
          $error("glyph: expected %0h, got %0h", exp_w.glyph, glyph);
          mismatches++;
        end
        if (erase_count !== exp_w.count) begin
          $error("erase_count: expected %0d, got %0d", exp_w.count, erase_count);
          mismatches++;
        end
        if (last_of_run !== exp_w.last) begin
          $error("last_of_run: expected %0d, got %0d", exp_w.last, last_of_run);
          mismatches++;
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(0, 99) < 29);
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [7:0] b;
    fill = 0;
    stopped = 1'b0;
    mismatches = 0;
    words_checked = 0;
    keys_sent = 0;
    wraps = 0;
    hard_wraps = 0;
    nospace_left = 0;
    quiet = 1'b0;
    for (int i = 0; i <= LW; i++) line_img[i] = 8'h00;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].check == CHK_ONE) begin
        send_typed(dir_rows[i].key, dir_rows[i].action, dir_rows[i].glyph, dir_rows[i].count);
      end else begin
        send_key(dir_rows[i].key, 1'b1);
        apply_key(dir_rows[i].key, dir_rows[i].check == CHK_PREDICT);
      end
    end

    for (int n = 0; n < N_RAND; n++) begin
      quiet = (n >= QUIET_LO) && (n < QUIET_HI);
      b = next_key();
      send_key(b, !quiet);
      apply_key(b, 1'b1);
    end
    quiet = 1'b0;

    // empty line, exit, then keys that the halted editor must ignore
    send_key(lew_pkg::KEY_CR, 1'b1);
    apply_key(lew_pkg::KEY_CR, 1'b1);
    send_typed(lew_pkg::KEY_CTRLD, lew_pkg::ACT_EXIT, 8'h00, 6'd0);
    for (int n = 0; n < 4; n++) begin
      b = 8'($urandom_range(0, 255));
      send_key(b, 1'b1);
      apply_key(b, 1'b1);
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d keys and %0d display words, %0d line wraps (%0d hard)",
             keys_sent, words_checked, wraps, hard_wraps);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
